>>> rtl/sdct_pkg.sv
// Shared types, constants and command codes for the saturating decay counter table.
package sdct_pkg;

  localparam int VAL_W     = 13;
  localparam int IDX_W     = 10;
  localparam int REV_W     = 64;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 11;
  localparam int ENTRY_W   = 2 * VAL_W + 1;

  localparam int MAX_ENTRIES_DEF = 1024;

  localparam logic [VAL_W-1:0] VALUE_CAP  = 13'd8000;
  localparam logic [VAL_W-1:0] LEARN_STEP = 13'd1200;
  localparam logic [VAL_W-1:0] LEARN_EDGE = VALUE_CAP - LEARN_STEP;
  localparam int               DECAY_SHIFT = 6;

  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ACTIVATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEARN    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DECAY    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_COMMIT   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SEEDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST      = 2'd1;

  typedef struct packed {
    logic             elig;
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] blue;
  } entry_t;

  typedef struct packed {
    entry_t learn_word;
    logic   learn_ok;
    entry_t decay_word;
    logic   decay_changed;
  } upd_t;

endpackage

>>> rtl/saturating_decay_counter_table_core.sv
// A single-entry command executes in S_EXEC and its result is registered at the output, or
// waits in S_RESP while the previous result is untaken. A new command is taken only in S_IDLE,
// after the last one is done (memory read, then modify and write back). Clear walks all
// MAX_ENTRIES entries; decay walks min(active_seeds, MAX_ENTRIES) entries, one per cycle.
// Reset: flags cleared at once, then a clearing pass over all MAX_ENTRIES entries with
// in_ready low; configuration writes are taken throughout.
module saturating_decay_counter_table_core #(
  parameter int MAX_ENTRIES = sdct_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sdct_pkg::CMD_W-1:0]     in_cmd,
  input  logic                           in_team,
  input  logic [sdct_pkg::IDX_W-1:0]     in_seed_index,
  input  logic [sdct_pkg::VAL_W-1:0]     in_red_value,
  input  logic [sdct_pkg::VAL_W-1:0]     in_blue_value,
  input  logic                           in_eligible,
  input  logic [sdct_pkg::REV_W-1:0]     in_commit_revision,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ok,
  output logic [sdct_pkg::VAL_W-1:0]     out_red_out,
  output logic [sdct_pkg::VAL_W-1:0]     out_blue_read,
  output logic                           out_dirty,
  output logic [sdct_pkg::REV_W-1:0]     out_revision,
  output logic                           out_checkpoint_pending,
  output logic                           out_active,
  input  logic                           cfg_we,
  input  logic [sdct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdct_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LW = ($clog2(MAX_ENTRIES + 1) > sdct_pkg::CFG_W) ?
                      $clog2(MAX_ENTRIES + 1) : sdct_pkg::CFG_W;
  localparam int VW = sdct_pkg::VAL_W;
  localparam int RW = sdct_pkg::REV_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_DECAY = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_ptr_r, clr_ptr_nxt;
  logic          clr_cmd_r, clr_cmd_nxt;
  logic [LW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic          changed_r, changed_nxt;

  logic          active_r, active_nxt;
  logic          dirty_r, dirty_nxt;
  logic [RW-1:0] rev_r, rev_nxt;
  logic          exh_r, exh_nxt;
  logic [sdct_pkg::CFG_W-1:0] as_r;
  logic          persist_r;

  logic          ok_r, ok_nxt;
  logic [VW-1:0] rred_r, rred_nxt;
  logic [VW-1:0] rblue_r, rblue_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_ok_r;
  logic [VW-1:0] out_red_r, out_blue_r;
  logic          out_dirty_r, out_cp_r, out_active_r;
  logic [RW-1:0] out_rev_r;

  // latched command
  logic [sdct_pkg::CMD_W-1:0] cmd_r;
  logic          team_r;
  logic [AW-1:0] idx_r;
  logic [VW-1:0] red_r, blue_r;
  logic          elig_r;
  logic          in_range_r;
  logic          crev_eq_r;

  logic [LW-1:0] limit;
  logic          accept;
  logic          slot_free;
  logic          out_load;
  logic          adv;
  logic          fin;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  sdct_pkg::entry_t mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [sdct_pkg::ENTRY_W-1:0] mem_rdata_raw;
  sdct_pkg::entry_t mem_rdata;
  sdct_pkg::upd_t   upd;

  sdct_ram #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW),
    .DW    (sdct_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata_raw)
  );

  assign mem_rdata = sdct_pkg::entry_t'(mem_rdata_raw);

  sdct_update u_update (
    .word (mem_rdata),
    .team (team_r),
    .upd  (upd)
  );

  assign limit     = (LW'(as_r) < LW'(MAX_ENTRIES)) ? LW'(as_r) : LW'(MAX_ENTRIES);
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    clr_ptr_nxt = clr_ptr_r;
    clr_cmd_nxt = clr_cmd_r;
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    changed_nxt = changed_r;
    active_nxt  = active_r;
    dirty_nxt   = dirty_r;
    rev_nxt     = rev_r;
    exh_nxt     = exh_r;
    ok_nxt      = ok_r;
    rred_nxt    = rred_r;
    rblue_nxt   = rblue_r;
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    mem_wdata   = '0;
    mem_raddr   = AW'(in_seed_index);
    out_load    = 1'b0;
    adv         = 1'b0;
    fin         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ok_nxt    = 1'b0;
        rred_nxt  = '0;
        rblue_nxt = '0;
        fin       = 1'b1;
        case (cmd_r)
          sdct_pkg::CMD_CLEAR: begin
            active_nxt  = 1'b0;
            dirty_nxt   = 1'b0;
            adv         = 1'b1;
            ok_nxt      = 1'b1;
            clr_ptr_nxt = '0;
            clr_cmd_nxt = 1'b1;
            fin         = 1'b0;
            state_nxt   = S_CLEAR;
          end
          sdct_pkg::CMD_LOAD: begin
            if (in_range_r && (red_r <= sdct_pkg::VALUE_CAP) &&
                (blue_r <= sdct_pkg::VALUE_CAP) &&
                (elig_r || ((red_r == '0) && (blue_r == '0)))) begin
              mem_we         = 1'b1;
              mem_wdata.elig = elig_r;
              mem_wdata.red  = red_r;
              mem_wdata.blue = blue_r;
              ok_nxt         = 1'b1;
            end
          end
          sdct_pkg::CMD_ACTIVATE: begin
            active_nxt = 1'b1;
            dirty_nxt  = 1'b0;
            adv        = 1'b1;
            ok_nxt     = 1'b1;
          end
          sdct_pkg::CMD_LEARN: begin
            if (active_r && in_range_r && upd.learn_ok) begin
              mem_we    = 1'b1;
              mem_wdata = upd.learn_word;
              dirty_nxt = 1'b1;
              adv       = 1'b1;
              ok_nxt    = 1'b1;
            end
          end
          sdct_pkg::CMD_DECAY: begin
            if (active_r) begin
              ok_nxt      = 1'b1;
              changed_nxt = 1'b0;
              if (limit != '0) begin
                mem_raddr  = '0;
                rd_ptr_nxt = LW'(1);
                wr_ptr_nxt = '0;
                fin        = 1'b0;
                state_nxt  = S_DECAY;
              end
            end
          end
          sdct_pkg::CMD_READ: begin
            if (in_range_r) begin
              ok_nxt    = 1'b1;
              rred_nxt  = mem_rdata.red;
              rblue_nxt = mem_rdata.blue;
            end
          end
          sdct_pkg::CMD_COMMIT: begin
            if (active_r && persist_r && !exh_r && crev_eq_r) begin
              dirty_nxt = 1'b0;
              ok_nxt    = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_r;
        mem_wdata = '0;
        if (clr_ptr_r == AW'(MAX_ENTRIES - 1)) begin
          state_nxt = clr_cmd_r ? S_RESP : S_IDLE;
        end else begin
          clr_ptr_nxt = clr_ptr_r + AW'(1);
        end
      end
      S_DECAY: begin
        // write back the word read last cycle while the next one, if any, is read
        mem_we      = 1'b1;
        mem_waddr   = wr_ptr_r[AW-1:0];
        mem_wdata   = upd.decay_word;
        changed_nxt = changed_r || upd.decay_changed;
        if (rd_ptr_r != limit) begin
          mem_raddr  = rd_ptr_r[AW-1:0];
          rd_ptr_nxt = rd_ptr_r + LW'(1);
          wr_ptr_nxt = rd_ptr_r;
        end else begin
          state_nxt = S_RESP;
          if (changed_nxt) begin
            dirty_nxt = 1'b1;
            adv       = 1'b1;
          end
        end
      end
      S_RESP: begin
        fin = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (adv) begin
      if (&rev_r) begin
        exh_nxt = 1'b1;
      end else begin
        rev_nxt = rev_r + RW'(1);
      end
    end

    if (fin) begin
      if (slot_free) begin
        out_load  = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        state_nxt = S_RESP;
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_ptr_r   <= '0;
      clr_cmd_r   <= 1'b0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      changed_r   <= 1'b0;
      active_r    <= 1'b0;
      dirty_r     <= 1'b0;
      rev_r       <= '0;
      exh_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      changed_r   <= changed_nxt;
      active_r    <= active_nxt;
      dirty_r     <= dirty_nxt;
      rev_r       <= rev_nxt;
      exh_r       <= exh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      as_r      <= '0;
      persist_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdct_pkg::CFG_ACTIVE_SEEDS: as_r      <= cfg_wdata;
        sdct_pkg::CFG_PERSIST:      persist_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    rred_r  <= rred_nxt;
    rblue_r <= rblue_nxt;
    if (accept) begin
      cmd_r      <= in_cmd;
      team_r     <= in_team;
      idx_r      <= AW'(in_seed_index);
      red_r      <= in_red_value;
      blue_r     <= in_blue_value;
      elig_r     <= in_eligible;
      in_range_r <= (LW'(in_seed_index) < limit);
      crev_eq_r  <= (in_commit_revision == rev_r);
    end
    if (out_load) begin
      out_ok_r     <= ok_nxt;
      out_red_r    <= rred_nxt;
      out_blue_r   <= rblue_nxt;
      out_dirty_r  <= dirty_nxt;
      out_rev_r    <= rev_nxt;
      out_cp_r     <= active_nxt && persist_r && dirty_nxt;
      out_active_r <= active_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_ok                 = out_ok_r;
  assign out_red_out            = out_red_r;
  assign out_blue_read          = out_blue_r;
  assign out_dirty              = out_dirty_r;
  assign out_revision           = out_rev_r;
  assign out_checkpoint_pending = out_cp_r;
  assign out_active             = out_active_r;

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("table written while idle");

  a_exh_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    exh_r |-> (&rev_r))
    else $error("revision exhausted below its maximum");

  a_rev_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (rev_r >= $past(rev_r)))
    else $error("revision went backwards");

  a_decay_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECAY) |-> (wr_ptr_r < limit))
    else $error("decay walk beyond entry limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_valid_r) |-> out_ready)
    else $error("result overwritten before transfer");

endmodule

>>> rtl/sdct_ram.sv
// Simple dual-port table memory: one write port, one registered read port.
module sdct_ram #(
  parameter int DEPTH = sdct_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = 10,
  parameter int DW    = sdct_pkg::ENTRY_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sdct_update.sv
// Per-entry modify logic: learn step and decay step on one table word.
module sdct_update (
  input  sdct_pkg::entry_t word,
  input  logic             team,
  output sdct_pkg::upd_t   upd
);

  logic [sdct_pkg::VAL_W-1:0] learn_v;
  logic [sdct_pkg::VAL_W-1:0] learn_nv;

  function automatic logic [sdct_pkg::VAL_W-1:0] decay_val(
    input logic [sdct_pkg::VAL_W-1:0] v
  );
    logic [sdct_pkg::VAL_W-1:0] d;
    d = (v >> sdct_pkg::DECAY_SHIFT) + sdct_pkg::VAL_W'(1);
    decay_val = (v != '0) ? (v - d) : v;
  endfunction

  always_comb begin
    learn_v  = team ? word.blue : word.red;
    learn_nv = (learn_v > sdct_pkg::LEARN_EDGE) ? sdct_pkg::VALUE_CAP
                                                 : (learn_v + sdct_pkg::LEARN_STEP);

    upd.learn_word = word;
    if (team) begin
      upd.learn_word.blue = learn_nv;
    end else begin
      upd.learn_word.red = learn_nv;
    end
    upd.learn_ok = word.elig && (learn_v < sdct_pkg::VALUE_CAP);

    upd.decay_word.elig = word.elig;
    upd.decay_word.red  = decay_val(word.red);
    upd.decay_word.blue = decay_val(word.blue);
    upd.decay_changed   = (word.red != '0) || (word.blue != '0);
  end

endmodule
